@@ src/dii_pkg.sv @@
// ----------------------------------------------------------------------------
// dii_pkg
// shared types and constants of the download-info message parser
// ----------------------------------------------------------------------------
package dii_pkg;

    localparam int unsigned MinLength  = 34;
    localparam int unsigned MaxBlock   = 4066;
    localparam logic [7:0]  TagName    = 8'h02;
    localparam logic [7:0]  TagCrc     = 8'h05;
    localparam int unsigned FifoDepth  = 4;

    typedef enum logic [1:0] {
        KIND_MODULE   = 2'd0,
        KIND_ACCEPTED = 2'd1,
        KIND_REJECTED = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] message_length;
        logic        first_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] message_ident;
        logic [31:0] transaction_ident;
        logic [31:0] download_ident;
        logic [11:0] block_bytes;
        logic [15:0] module_ident;
        logic [31:0] module_bytes;
        logic [7:0]  module_version;
        logic [15:0] name_offset;
        logic [7:0]  name_length;
        logic        crc_present;
        logic [31:0] crc_value;
    } t_out_word;

endpackage

@@ src/dii_fifo.sv @@
// ----------------------------------------------------------------------------
// dii_fifo
// small synchronous queue of words, push/full and pop/empty
// ----------------------------------------------------------------------------
module dii_fifo #(
    parameter int unsigned Depth = dii_pkg::FifoDepth,
    parameter int unsigned Width = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [Width-1:0] i_data,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [Width-1:0] o_data
);
    localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

    logic [Width-1:0] r_mem [Depth];
    logic [Aw-1:0]    r_wr, r_rd;
    logic [Aw:0]      r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == (Aw+1)'(Depth));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == Aw'(Depth-1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == Aw'(Depth-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (Aw+1)'(w_push) - (Aw+1)'(w_pop);
        end
    end
endmodule

@@ src/dii_parse.sv @@
// ----------------------------------------------------------------------------
// dii_parse
// byte-serial parser, up to two result words per byte into a result queue
// ----------------------------------------------------------------------------
module dii_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  dii_pkg::t_in_word  i_word,
    output logic               o_ready,
    output logic               o_push,
    output dii_pkg::t_out_word o_word,
    input  logic               i_full,
    input  logic               i_almost
);
    typedef enum logic [3:0] {
        PH_WAIT, PH_HEAD, PH_ADAPT, PH_DLHEAD, PH_COMPAT,
        PH_COUNT, PH_MODHEAD, PH_INFO, PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_pos, n_pos, r_nfp, n_nfp;
    logic [7:0]  r_adapt, n_adapt;
    logic [15:0] r_msg, n_msg;
    logic [31:0] r_trans, n_trans, r_dl, n_dl;
    logic [15:0] r_blk, n_blk, r_skip, n_skip, r_left, n_left;
    logic [15:0] r_mid, n_mid;
    logic [31:0] r_msize, n_msize;
    logic [7:0]  r_mver, n_mver, r_ilen, n_ilen, r_ipos, n_ipos;
    logic [7:0]  r_dtag, n_dtag, r_dlen, n_dlen;
    logic [15:0] r_noff, n_noff;
    logic [7:0]  r_nlen, n_nlen;
    logic        r_cv, n_cv, r_rej, n_rej;
    logic [31:0] r_crc, n_crc;
    logic [1:0]  r_dstep, n_dstep;
    logic [7:0]  r_dnext, n_dnext;
    logic        r_hold, n_hold;
    dii_pkg::t_out_word r_held, n_held;

    logic        w_acc, w_rec, w_stat;
    logic [7:0]  b;
    logic [15:0] pos, k;
    logic [8:0]  body;
    logic [9:0]  bsum;
    dii_pkg::t_out_word w_recw, w_statw;

    assign o_ready = !r_hold && !i_almost && !i_full;
    assign w_acc   = i_valid && o_ready;
    assign b       = i_word.data_byte;

    function automatic dii_pkg::t_out_word mk(input logic [1:0] kind, input logic m,
        input logic [15:0] msg, input logic [31:0] tr, input logic [31:0] dl,
        input logic [15:0] blk, input logic [15:0] mid, input logic [31:0] ms,
        input logic [7:0] mv, input logic [15:0] no, input logic [7:0] nl,
        input logic cv, input logic [31:0] crc);
        dii_pkg::t_out_word w;
        w.result_kind       = kind;
        w.message_ident     = msg;
        w.transaction_ident = tr;
        w.download_ident    = dl;
        w.block_bytes       = blk[11:0];
        w.module_ident      = m ? mid : '0;
        w.module_bytes      = m ? ms : '0;
        w.module_version    = m ? mv : '0;
        w.name_offset       = m ? no : '0;
        w.name_length       = m ? nl : '0;
        w.crc_present       = m ? cv : 1'b0;
        w.crc_value         = (m && cv) ? crc : '0;
        return w;
    endfunction

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_nfp = r_nfp; n_adapt = r_adapt;
        n_msg = r_msg; n_trans = r_trans; n_dl = r_dl; n_blk = r_blk;
        n_skip = r_skip; n_left = r_left; n_mid = r_mid; n_msize = r_msize;
        n_mver = r_mver; n_ilen = r_ilen; n_ipos = r_ipos; n_dtag = r_dtag;
        n_dlen = r_dlen; n_noff = r_noff; n_nlen = r_nlen; n_cv = r_cv;
        n_crc = r_crc; n_dstep = r_dstep; n_dnext = r_dnext; n_rej = r_rej;
        n_hold = r_hold; n_held = r_held;
        w_rec = 1'b0; w_stat = 1'b0;
        pos = r_pos; k = '0; body = '0; bsum = '0;
        w_recw = '0; w_statw = '0;
        o_push = 1'b0; o_word = r_held;
        if (r_hold && !i_full) begin
            o_push = 1'b1;
            n_hold = 1'b0;
        end
        if (w_acc && (i_word.first_byte || r_phase != PH_WAIT)) begin
            if (i_word.first_byte) begin
                n_nfp = '0; n_adapt = '0; n_msg = '0; n_trans = '0; n_dl = '0;
                n_blk = '0; n_skip = '0; n_left = '0; n_rej = 1'b0;
                n_mid = '0; n_msize = '0; n_mver = '0; n_ilen = '0; n_ipos = '0;
                n_dtag = '0; n_dlen = '0; n_noff = '0; n_nlen = '0; n_cv = 1'b0;
                n_crc = '0; n_dstep = '0; n_dnext = '0;
                pos = '0;
                n_phase = PH_HEAD;
                if (i_word.message_length < 16'(dii_pkg::MinLength)) begin
                    n_rej = 1'b1; n_phase = PH_DONE;
                end
            end
            k = pos - n_nfp;
            unique case (n_phase)
                PH_HEAD: begin
                    if (k == 16'd2 || k == 16'd3) n_msg = {n_msg[7:0], b};
                    else if (k >= 16'd4 && k <= 16'd7) n_trans = {n_trans[23:0], b};
                    else if (k == 16'd9) n_adapt = b;
                    else if (k == 16'd11) begin
                        n_phase = (n_adapt != 0) ? PH_ADAPT : PH_DLHEAD;
                        n_nfp = pos + 16'd1;
                    end
                end
                PH_ADAPT: begin
                    if (17'(k) + 17'd1 >= 17'(n_adapt)) begin
                        n_phase = PH_DLHEAD; n_nfp = pos + 16'd1;
                    end
                end
                PH_DLHEAD: begin
                    if (k <= 16'd3) n_dl = {n_dl[23:0], b};
                    else if (k == 16'd4 || k == 16'd5) begin
                        n_blk = {n_blk[7:0], b};
                        if (k == 16'd5 && (n_blk == '0 || n_blk > 16'(dii_pkg::MaxBlock)))
                        begin
                            n_rej = 1'b1; n_phase = PH_DONE;
                        end
                    end else if (k == 16'd16 || k == 16'd17) begin
                        n_skip = {n_skip[7:0], b};
                        if (k == 16'd17) begin
                            n_phase = (n_skip != 0) ? PH_COMPAT : PH_COUNT;
                            n_nfp = pos + 16'd1;
                        end
                    end
                end
                PH_COMPAT: begin
                    if (17'(k) + 17'd1 >= 17'(n_skip)) begin
                        n_phase = PH_COUNT; n_nfp = pos + 16'd1;
                    end
                end
                PH_COUNT: begin
                    n_left = {n_left[7:0], b};
                    if (k >= 16'd1) begin
                        if (n_left == '0) n_phase = PH_DONE;
                        else begin
                            n_phase = PH_MODHEAD; n_nfp = pos + 16'd1;
                        end
                    end
                end
                PH_MODHEAD: begin
                    if (k == 16'd0) begin
                        n_mid = '0; n_msize = '0; n_mver = '0; n_noff = '0;
                        n_nlen = '0; n_cv = 1'b0; n_crc = '0;
                    end
                    if (k <= 16'd1) n_mid = {n_mid[7:0], b};
                    else if (k <= 16'd5) n_msize = {n_msize[23:0], b};
                    else if (k == 16'd6) n_mver = b;
                    else begin
                        n_ilen = b; n_ipos = '0; n_dstep = '0; n_dnext = '0;
                        n_dtag = '0; n_dlen = '0;
                        if (b == '0) w_rec = 1'b1;
                        else begin
                            n_phase = PH_INFO; n_nfp = pos + 16'd1;
                        end
                    end
                end
                PH_INFO: begin
                    unique case (r_dstep)
                        2'd0: begin
                            if (9'(r_dnext) + 9'd2 < 9'(r_ilen)) begin
                                n_dtag = b; n_dstep = 2'd1;
                            end else n_dstep = 2'd3;
                        end
                        2'd1: begin
                            body = 9'(r_dnext) + 9'd2;
                            bsum = 10'(body) + 10'(b);
                            n_dlen = b;
                            if (bsum > 10'(r_ilen)) n_dstep = 2'd3;
                            else begin
                                if (r_dtag == dii_pkg::TagName) begin
                                    n_noff = pos + 16'd1; n_nlen = b;
                                end else if (r_dtag == dii_pkg::TagCrc && b == 8'd4) begin
                                    n_cv = 1'b1; n_crc = '0;
                                end
                                n_dnext = bsum[7:0];
                                n_dstep = (b != 0) ? 2'd2 : 2'd0;
                            end
                        end
                        2'd2: begin
                            if (r_dtag == dii_pkg::TagCrc && r_dlen == 8'd4)
                                n_crc = {r_crc[23:0], b};
                            if (9'(r_ipos) + 9'd1 == 9'(r_dnext)) n_dstep = 2'd0;
                        end
                        default: ;
                    endcase
                    if (9'(r_ipos) + 9'd1 >= 9'(r_ilen)) w_rec = 1'b1;
                    else n_ipos = r_ipos + 8'd1;
                end
                default: ;
            endcase
            w_recw = mk(dii_pkg::KIND_MODULE, 1'b1, n_msg, n_trans, n_dl, n_blk,
                        n_mid, n_msize, n_mver, n_noff, n_nlen, n_cv, n_crc);
            if (w_rec) begin
                n_left = n_left - 16'd1;
                if (n_left == '0) n_phase = PH_DONE;
                else begin
                    n_phase = PH_MODHEAD; n_nfp = pos + 16'd1;
                end
            end
            if (17'(pos) + 17'd1 >= 17'(i_word.message_length)) begin
                w_stat = 1'b1;
                w_statw = mk((!n_rej && n_phase == PH_DONE) ? dii_pkg::KIND_ACCEPTED
                             : dii_pkg::KIND_REJECTED, 1'b0, n_msg, n_trans, n_dl,
                             n_blk, '0, '0, '0, '0, '0, 1'b0, '0);
                n_phase = PH_WAIT;
                n_pos = '0;
            end else n_pos = pos + 16'd1;
            o_push = 1'b1;
            if (w_rec) begin
                o_word = w_recw;
                if (w_stat) begin
                    n_hold = 1'b1; n_held = w_statw;
                end
            end else if (w_stat) o_word = w_statw;
            else o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nfp <= n_nfp; r_adapt <= n_adapt; r_msg <= n_msg; r_trans <= n_trans;
        r_dl <= n_dl; r_blk <= n_blk; r_skip <= n_skip; r_left <= n_left;
        r_mid <= n_mid; r_msize <= n_msize; r_mver <= n_mver; r_ilen <= n_ilen;
        r_ipos <= n_ipos; r_dtag <= n_dtag; r_dlen <= n_dlen; r_noff <= n_noff;
        r_nlen <= n_nlen; r_cv <= n_cv; r_crc <= n_crc; r_dstep <= n_dstep;
        r_dnext <= n_dnext; r_rej <= n_rej; r_held <= n_held;
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_pos   <= '0;
            r_hold  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_hold  <= n_hold;
        end
    end
endmodule

@@ src/download_info_message_parser.sv @@
// ----------------------------------------------------------------------------
// download_info_message_parser
// path: each byte goes through the input queue, the parser and the result queue
// throughput: one byte per cycle while the result queue has room; a byte
// giving two words holds the next back; parser and result queue set the rate
// reset: synchronous active low, queues empty, parser waits for a first byte
// ----------------------------------------------------------------------------
module download_info_message_parser #(
    parameter int unsigned FifoDepth = dii_pkg::FifoDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_message_length,
    input  logic        i_first_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_result_kind,
    output logic [15:0] o_message_ident,
    output logic [31:0] o_transaction_ident,
    output logic [31:0] o_download_ident,
    output logic [11:0] o_block_bytes,
    output logic [15:0] o_module_ident,
    output logic [31:0] o_module_bytes,
    output logic [7:0]  o_module_version,
    output logic [15:0] o_name_offset,
    output logic [7:0]  o_name_length,
    output logic        o_crc_present,
    output logic [31:0] o_crc_value
);
    localparam int unsigned InW  = $bits(dii_pkg::t_in_word);
    localparam int unsigned OutW = $bits(dii_pkg::t_out_word);
    localparam int unsigned CntW = $clog2(FifoDepth + 1);

    dii_pkg::t_in_word  w_in, w_q;
    dii_pkg::t_out_word w_pw, w_ow;
    logic w_qempty, w_rdy, w_ppush, w_rfull;
    logic [OutW-1:0] w_od;
    logic w_af, w_fempty;
    logic [CntW-1:0] r_cnt;

    assign w_in = '{data_byte: i_data_byte, message_length: i_message_length,
                    first_byte: i_first_byte};

    dii_fifo #(.Depth(FifoDepth), .Width(InW)) u_in (
        .i_clk, .i_rst_n, .i_push(push), .i_data(w_in), .o_full(full),
        .o_empty(w_qempty), .i_pop(w_rdy), .o_data(w_q)
    );

    // almost-full guard: leave room for a byte's two words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= '0;
        else r_cnt <= r_cnt + CntW'(w_ppush && !w_rfull) - CntW'(pop && !w_fempty);
    end
    assign w_af = (r_cnt >= CntW'(FifoDepth - 1));

    dii_parse u_parse (
        .i_clk, .i_rst_n, .i_valid(!w_qempty), .i_word(w_q), .o_ready(w_rdy),
        .o_push(w_ppush), .o_word(w_pw), .i_full(w_rfull), .i_almost(w_af)
    );

    dii_fifo #(.Depth(FifoDepth), .Width(OutW)) u_out (
        .i_clk, .i_rst_n, .i_push(w_ppush), .i_data(w_pw), .o_full(w_rfull),
        .o_empty(w_fempty), .i_pop(pop), .o_data(w_od)
    );

    assign w_ow  = w_od;
    assign empty = w_fempty;
    assign o_result_kind       = w_ow.result_kind;
    assign o_message_ident     = w_ow.message_ident;
    assign o_transaction_ident = w_ow.transaction_ident;
    assign o_download_ident    = w_ow.download_ident;
    assign o_block_bytes       = w_ow.block_bytes;
    assign o_module_ident      = w_ow.module_ident;
    assign o_module_bytes      = w_ow.module_bytes;
    assign o_module_version    = w_ow.module_version;
    assign o_name_offset       = w_ow.name_offset;
    assign o_name_length       = w_ow.name_length;
    assign o_crc_present       = w_ow.crc_present;
    assign o_crc_value         = w_ow.crc_value;

    a_no_lost_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ppush && w_rfull)) else $error("result word pushed into full queue");
    a_cnt_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) == w_fempty) else $error("result count out of step");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_result_kind != 2'd3) else $error("bad result kind");
endmodule

@@ bench/tb_download_info_message_parser.sv @@
// ----------------------------------------------------------------------------
// tb_download_info_message_parser
// Self-checking bench for the download-info message parser. Directed short,
// stray and restarted messages come first, then random messages: mostly
// well-formed with random content, plus bad block sizes, truncation,
// descriptor overrun, trailing bytes and noise. Each pushed byte is run
// through a cycle-free model of the parser, and every popped word is compared
// field by field with the oldest predicted word. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_download_info_message_parser;

    typedef enum int unsigned {
        PH_WAIT, PH_HEAD, PH_ADAPT, PH_DLHEAD, PH_COMPAT,
        PH_COUNT, PH_MODHEAD, PH_INFO, PH_DONE
    } t_phase;

    class dii_scoreboard;
        dii_pkg::t_out_word expected_words[$];
        int          errors = 0;
        t_phase      phase = PH_WAIT;
        int unsigned byte_pos = 0, field_start, adapt_len, msg_id, trans_id, dl_id;
        int unsigned blk_size, compat_len, mods_left, mod_id, mod_size, mod_ver;
        int unsigned info_len, info_pos, desc_tag, desc_len, name_off, name_len;
        int unsigned crc_ok, crc_word, rejected, desc_step, desc_next;

        function void clear_module();
            mod_id = 0; mod_size = 0; mod_ver = 0; info_len = 0; info_pos = 0;
            desc_tag = 0; desc_len = 0; name_off = 0; name_len = 0;
            crc_ok = 0; crc_word = 0; desc_step = 0; desc_next = 0;
        endfunction

        function void clear_message();
            field_start = 0; adapt_len = 0; msg_id = 0; trans_id = 0; dl_id = 0;
            blk_size = 0; compat_len = 0; mods_left = 0; rejected = 0;
            clear_module();
        endfunction

        function new();
            clear_message();
        endfunction

        function void add_word(dii_pkg::t_kind kind, bit is_mod);
            dii_pkg::t_out_word w;
            w.result_kind       = kind;
            w.message_ident     = msg_id[15:0];
            w.transaction_ident = trans_id;
            w.download_ident    = dl_id;
            w.block_bytes       = blk_size[11:0];
            w.module_ident      = is_mod ? mod_id[15:0] : '0;
            w.module_bytes      = is_mod ? mod_size : '0;
            w.module_version    = is_mod ? mod_ver[7:0] : '0;
            w.name_offset       = is_mod ? name_off[15:0] : '0;
            w.name_length       = is_mod ? name_len[7:0] : '0;
            w.crc_present       = is_mod ? crc_ok[0] : 1'b0;
            w.crc_value         = (is_mod && crc_ok[0]) ? crc_word : '0;
            expected_words.push_back(w);
        endfunction

        function void start_field(t_phase p, int unsigned start);
            phase = p;
            field_start = start & 16'hFFFF;
        endfunction

        function void module_done(int unsigned pos);
            mods_left = (mods_left - 1) & 16'hFFFF;
            if (mods_left == 0) phase = PH_DONE;
            else start_field(PH_MODHEAD, pos + 1);
        endfunction

        function void info_byte(int unsigned b, int unsigned pos);
            int unsigned body;
            bit crc_body;
            crc_body = (desc_tag == dii_pkg::TagCrc && desc_len == 4);
            if (desc_step == 0) begin
                if (desc_next + 2 < info_len) begin
                    desc_tag = b; desc_step = 1;
                end else desc_step = 3;
            end else if (desc_step == 1) begin
                body = desc_next + 2;
                desc_len = b;
                if (body + b > info_len) desc_step = 3;
                else begin
                    if (desc_tag == dii_pkg::TagName) begin
                        name_off = (pos + 1) & 16'hFFFF; name_len = b;
                    end else if (desc_tag == dii_pkg::TagCrc && b == 4) begin
                        crc_ok = 1; crc_word = 0;
                    end
                    desc_next = body + b;
                    desc_step = (b != 0) ? 2 : 0;
                end
            end else if (desc_step == 2) begin
                if (crc_body) crc_word = (crc_word << 8) | b;
                if (info_pos + 1 == desc_next) desc_step = 0;
            end
            if (info_pos + 1 >= info_len) begin
                add_word(dii_pkg::KIND_MODULE, 1);
                module_done(pos);
            end else info_pos = info_pos + 1;
        endfunction

        function void note_byte(logic [7:0] data, logic [15:0] len, logic first);
            int unsigned b, ln, pos, k;
            b = data; ln = len;
            if (first) begin
                clear_message();
                byte_pos = 0;
                start_field(PH_HEAD, 0);
                if (ln < dii_pkg::MinLength) begin
                    rejected = 1; phase = PH_DONE;
                end
            end else if (phase == PH_WAIT) return;
            pos = byte_pos & 16'hFFFF;
            k = (pos - field_start) & 16'hFFFF;
            case (phase)
                PH_HEAD: begin
                    if (k == 2 || k == 3) msg_id = ((msg_id << 8) | b) & 16'hFFFF;
                    else if (k >= 4 && k <= 7) trans_id = (trans_id << 8) | b;
                    else if (k == 9) adapt_len = b;
                    else if (k == 11) start_field(adapt_len ? PH_ADAPT : PH_DLHEAD, pos + 1);
                end
                PH_ADAPT: if (k + 1 >= adapt_len) start_field(PH_DLHEAD, pos + 1);
                PH_DLHEAD: begin
                    if (k <= 3) dl_id = (dl_id << 8) | b;
                    else if (k == 4 || k == 5) begin
                        blk_size = ((blk_size << 8) | b) & 16'hFFFF;
                        if (k == 5 && (blk_size == 0 || blk_size > dii_pkg::MaxBlock)) begin
                            rejected = 1; phase = PH_DONE;
                        end
                    end else if (k == 16 || k == 17) begin
                        compat_len = ((compat_len << 8) | b) & 16'hFFFF;
                        if (k == 17) start_field(compat_len ? PH_COMPAT : PH_COUNT, pos + 1);
                    end
                end
                PH_COMPAT: if (k + 1 >= compat_len) start_field(PH_COUNT, pos + 1);
                PH_COUNT: begin
                    mods_left = ((mods_left << 8) | b) & 16'hFFFF;
                    if (k >= 1) begin
                        if (mods_left == 0) phase = PH_DONE;
                        else start_field(PH_MODHEAD, pos + 1);
                    end
                end
                PH_MODHEAD: begin
                    if (k == 0) clear_module();
                    if (k <= 1) mod_id = ((mod_id << 8) | b) & 16'hFFFF;
                    else if (k <= 5) mod_size = (mod_size << 8) | b;
                    else if (k == 6) mod_ver = b;
                    else begin
                        info_len = b; info_pos = 0; desc_step = 0; desc_next = 0;
                        desc_tag = 0; desc_len = 0;
                        if (info_len == 0) begin
                            add_word(dii_pkg::KIND_MODULE, 1);
                            module_done(pos);
                        end else start_field(PH_INFO, pos + 1);
                    end
                end
                PH_INFO: info_byte(b, pos);
                default: ;
            endcase
            if (pos + 1 >= ln) begin
                add_word((rejected == 0 && phase == PH_DONE) ? dii_pkg::KIND_ACCEPTED
                                                             : dii_pkg::KIND_REJECTED, 0);
                phase = PH_WAIT;
                byte_pos = 0;
            end else byte_pos = (pos + 1) & 16'hFFFF;
        endfunction

        function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s expected %0h actual %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_word(dii_pkg::t_out_word got);
            dii_pkg::t_out_word e;
            if (expected_words.size() == 0) begin
                $error("word popped with none expected");
                errors++;
                return;
            end
            e = expected_words.pop_front();
            compare("result_kind", e.result_kind, got.result_kind);
            compare("message_ident", e.message_ident, got.message_ident);
            compare("transaction_ident", e.transaction_ident, got.transaction_ident);
            compare("download_ident", e.download_ident, got.download_ident);
            compare("block_bytes", e.block_bytes, got.block_bytes);
            compare("module_ident", e.module_ident, got.module_ident);
            compare("module_bytes", e.module_bytes, got.module_bytes);
            compare("module_version", e.module_version, got.module_version);
            compare("name_offset", e.name_offset, got.name_offset);
            compare("name_length", e.name_length, got.name_length);
            compare("crc_present", e.crc_present, got.crc_present);
            compare("crc_value", e.crc_value, got.crc_value);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic [15:0] i_message_length = '0;
    logic        i_first_byte = 1'b0;
    logic        full, empty;
    logic [1:0]  o_result_kind;
    logic [15:0] o_message_ident, o_module_ident, o_name_offset;
    logic [31:0] o_transaction_ident, o_download_ident, o_module_bytes, o_crc_value;
    logic [11:0] o_block_bytes;
    logic [7:0]  o_module_version, o_name_length;
    logic        o_crc_present;

    dii_scoreboard sb = new();
    bit            send_idle = 1'b1;
    bit            recv_idle = 1'b1;
    int            sent_bytes = 0;
    logic [7:0]    msg_bytes[$];

    download_info_message_parser uut (.*);

    always #5 i_clk = ~i_clk;

    task automatic send_word(logic [7:0] b, logic [15:0] len, logic first);
        int gap;
        gap = send_idle ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push             <= 1'b1;
        i_data_byte      <= b;
        i_message_length <= len;
        i_first_byte     <= first;
        do @(posedge i_clk); while (full);
        sb.note_byte(b, len, first);
        sent_bytes++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_random(int n);
        repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_field(int unsigned v, int n);
        for (int i = n - 1; i >= 0; i--) msg_bytes.push_back(8'(v >> (8 * i)));
    endtask

    task automatic build_message();
        int unsigned adapt, compat, blk, nmods, info, rem, dlen, tag;
        msg_bytes.delete();
        adapt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        compat = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        case ($urandom_range(0, 9))
            0: blk = 0;
            1: blk = $urandom_range(dii_pkg::MaxBlock + 1, 65535);
            2: blk = dii_pkg::MaxBlock;
            3: blk = 1;
            default: blk = $urandom_range(1, dii_pkg::MaxBlock);
        endcase
        nmods = $urandom_range(0, 4);
        add_random(9);
        add_field(adapt, 1);
        add_random(2 + adapt + 4);
        add_field(blk, 2);
        add_random(10);
        add_field(compat, 2);
        add_random(compat);
        add_field(nmods, 2);
        repeat (nmods) begin
            add_random(7);
            info = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
            add_field(info, 1);
            rem = info;
            while (rem != 0) begin
                if (rem < 3) begin
                    add_random(rem);
                    rem = 0;
                end else begin
                    case ($urandom_range(0, 3))
                        0: tag = dii_pkg::TagName;
                        1, 2: tag = dii_pkg::TagCrc;
                        default: tag = $urandom_range(0, 255);
                    endcase
                    if ($urandom_range(0, 7) == 0) dlen = $urandom_range(rem - 1, 255);
                    else if (tag == dii_pkg::TagCrc && rem >= 6 && $urandom_range(0, 3) != 0)
                        dlen = 4;
                    else dlen = $urandom_range(0, rem - 2);
                    add_field(tag, 1);
                    add_field(dlen, 1);
                    if (dlen + 2 > rem) begin
                        add_random(rem - 2);
                        rem = 0;
                    end else begin
                        add_random(dlen);
                        rem -= dlen + 2;
                    end
                end
            end
        end
        if ($urandom_range(0, 2) == 0) add_random($urandom_range(1, 4));
    endtask

    task automatic send_message();
        int unsigned len, count;
        len = msg_bytes.size();
        if ($urandom_range(0, 5) == 0) len = $urandom_range(1, len);
        count = len;
        if ($urandom_range(0, 9) == 0) count = $urandom_range(1, len);
        for (int i = 0; i < count; i++) send_word(msg_bytes[i], len[15:0], i == 0);
    endtask

    initial begin
        dii_pkg::t_out_word got;
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = recv_idle ? $urandom_range(0, 15) : 0;
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got = '{o_result_kind, o_message_ident, o_transaction_ident, o_download_ident,
                    o_block_bytes, o_module_ident, o_module_bytes, o_module_version,
                    o_name_offset, o_name_length, o_crc_present, o_crc_value};
            sb.check_word(got);
            if ($urandom_range(0, 31) == 0) recv_idle = ~recv_idle;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // stray, zero length, one byte, short and abandoned messages
        send_word(8'hFF, 16'hFFFF, 1'b0);
        send_word(8'h00, 16'h0000, 1'b1);
        send_word(8'hA5, 16'h0001, 1'b1);
        send_word(8'h5A, 16'd33, 1'b1);
        send_word(8'hFF, 16'd33, 1'b0);
        send_word(8'h00, 16'hFFFF, 1'b1);
        send_word(8'hFF, 16'hFFFF, 1'b0);
        send_word(8'h12, 16'h0002, 1'b1);
        send_word(8'h34, 16'h0002, 1'b0);
        send_word(8'h77, 16'h8000, 1'b0);
        drain();
        while (sent_bytes < 520) begin
            send_idle = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3))
                    send_word(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                              1'b0);
            if ($urandom_range(0, 11) == 0)
                send_word(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 1'b1);
            build_message();
            send_message();
            if ($urandom_range(0, 9) == 0) drain();
        end
        push <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
src/dii_pkg.sv
src/dii_fifo.sv
src/dii_parse.sv
src/download_info_message_parser.sv
bench/tb_download_info_message_parser.sv
